[hw/rtl/tfl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfl_pkg
// Shared types and codes of the two-finger long press detector.
// ----------------------------------------------------------------------------
package tfl_pkg;

  localparam int MOVE_RADIUS_W = 13;
  localparam int HOLD_TICKS_W  = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 1;

  localparam logic [MOVE_RADIUS_W-1:0] MOVE_RADIUS_RST = 13'd20;
  localparam logic [HOLD_TICKS_W-1:0]  HOLD_TICKS_RST  = 16'd500;

  localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_RADIUS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS  = 1'b1;

  localparam logic OP_TOUCH = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [7:0] ACT_DOWN     = 8'd0;
  localparam logic [7:0] ACT_UP       = 8'd1;
  localparam logic [7:0] ACT_MOVE     = 8'd2;
  localparam logic [7:0] ACT_PTR_DOWN = 8'd5;
  localparam logic [7:0] ACT_PTR_UP   = 8'd6;

  localparam logic [3:0] PAIR_COUNT = 4'd2;

  typedef enum logic [2:0] {
    PH_NONE     = 3'd0,
    PH_MAYBE    = 3'd1,
    PH_STARTED  = 3'd2,
    PH_UPDATED  = 3'd3,
    PH_FINISHED = 3'd4
  } phase_t;

  typedef struct packed {
    logic       operation;
    logic       ignore_request;
    logic       points_present;
    logic       inside_region;
    logic [7:0] action_code;
    logic [3:0] point_count;
  } flags_t;

  typedef struct packed {
    logic   trigger;
    phase_t gesture_phase;
  } result_t;

  typedef struct packed {
    logic [MOVE_RADIUS_W-1:0] move_radius;
    logic [HOLD_TICKS_W-1:0]  hold_ticks;
  } cfg_t;

endpackage
`default_nettype wire

[hw/rtl/tfl_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfl_cfg
// Configuration registers: move radius and hold time.
// ----------------------------------------------------------------------------
module tfl_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_write_en,
  input  wire logic [tfl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tfl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tfl_pkg::cfg_t                       cfg
);
  import tfl_pkg::*;

  logic [MOVE_RADIUS_W-1:0] move_radius_r;
  logic [HOLD_TICKS_W-1:0]  hold_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_radius_r <= MOVE_RADIUS_RST;
      hold_ticks_r  <= HOLD_TICKS_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_MOVE_RADIUS: move_radius_r <= cfg_data[MOVE_RADIUS_W-1:0];
        CFG_HOLD_TICKS:  hold_ticks_r  <= cfg_data[HOLD_TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.move_radius = move_radius_r;
  assign cfg.hold_ticks  = hold_ticks_r;

endmodule
`default_nettype wire

[hw/rtl/tfl_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfl_in_stage
// Input register: captures one transaction and holds it until processed.
// ----------------------------------------------------------------------------
module tfl_in_stage #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire tfl_pkg::flags_t       in_flags,
  input  wire logic [COORD_BITS-1:0] in_first_x,
  input  wire logic [COORD_BITS-1:0] in_first_y,
  input  wire logic [COORD_BITS-1:0] in_second_x,
  input  wire logic [COORD_BITS-1:0] in_second_y,
  input  wire logic                  advance,
  output logic                       item_valid,
  output tfl_pkg::flags_t            item_flags,
  output logic [COORD_BITS-1:0]      item_first_x,
  output logic [COORD_BITS-1:0]      item_first_y,
  output logic [COORD_BITS-1:0]      item_second_x,
  output logic [COORD_BITS-1:0]      item_second_y
);
  import tfl_pkg::*;

  logic                  valid_r;
  logic                  valid_nxt;
  flags_t                flags_r;
  logic [COORD_BITS-1:0] first_x_r;
  logic [COORD_BITS-1:0] first_y_r;
  logic [COORD_BITS-1:0] second_x_r;
  logic [COORD_BITS-1:0] second_y_r;
  logic                  accept;

  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flags_r    <= in_flags;
      first_x_r  <= in_first_x;
      first_y_r  <= in_first_y;
      second_x_r <= in_second_x;
      second_y_r <= in_second_y;
    end
  end

  assign item_valid    = valid_r;
  assign item_flags    = flags_r;
  assign item_first_x  = first_x_r;
  assign item_first_y  = first_y_r;
  assign item_second_x = second_x_r;
  assign item_second_y = second_y_r;

endmodule
`default_nettype wire

[hw/rtl/tfl_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfl_core
// Gesture state, anchors and hold timer; one-pass update per transaction.
// ----------------------------------------------------------------------------
module tfl_core #(
  parameter int COORD_BITS = 12,
  parameter int TIMER_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  advance,
  input  wire tfl_pkg::cfg_t         cfg,
  input  wire tfl_pkg::flags_t       flags,
  input  wire logic [COORD_BITS-1:0] first_x,
  input  wire logic [COORD_BITS-1:0] first_y,
  input  wire logic [COORD_BITS-1:0] second_x,
  input  wire logic [COORD_BITS-1:0] second_y,
  output tfl_pkg::result_t           result
);
  import tfl_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int CW = (DW > MOVE_RADIUS_W) ? DW : MOVE_RADIUS_W;
  localparam int LW = (TIMER_BITS > HOLD_TICKS_W) ? TIMER_BITS : HOLD_TICKS_W;

  phase_t                phase_r, phase_nxt;
  logic [COORD_BITS-1:0] anc_fx_r, anc_fx_nxt;
  logic [COORD_BITS-1:0] anc_fy_r, anc_fy_nxt;
  logic [COORD_BITS-1:0] anc_sx_r, anc_sx_nxt;
  logic [COORD_BITS-1:0] anc_sy_r, anc_sy_nxt;
  logic                  fresh_r, fresh_nxt;
  logic                  running_r, running_nxt;
  logic [TIMER_BITS-1:0] remain_r, remain_nxt;
  logic                  trig;

  logic                  is_active;
  logic                  is_maybe;
  logic                  pair;
  logic [COORD_BITS-1:0] dfx, dfy, dsx, dsy;
  logic [DW-1:0]         d1, d2;
  logic                  too_far;
  logic [LW-1:0]         hold_wide;
  logic [LW-1:0]         tmax_wide;
  logic [TIMER_BITS-1:0] load;

  assign is_active = (phase_r == PH_STARTED) || (phase_r == PH_UPDATED);
  assign is_maybe  = (phase_r == PH_MAYBE);
  assign pair      = (flags.point_count == PAIR_COUNT);

  assign dfx = (anc_fx_r > first_x)  ? anc_fx_r - first_x  : first_x  - anc_fx_r;
  assign dfy = (anc_fy_r > first_y)  ? anc_fy_r - first_y  : first_y  - anc_fy_r;
  assign dsx = (anc_sx_r > second_x) ? anc_sx_r - second_x : second_x - anc_sx_r;
  assign dsy = (anc_sy_r > second_y) ? anc_sy_r - second_y : second_y - anc_sy_r;
  assign d1  = DW'(dfx) + DW'(dfy);
  assign d2  = DW'(dsx) + DW'(dsy);
  assign too_far = (CW'(d1) > CW'(cfg.move_radius)) || (CW'(d2) > CW'(cfg.move_radius));

  assign hold_wide = LW'(cfg.hold_ticks);
  assign tmax_wide = LW'({TIMER_BITS{1'b1}});
  assign load = (hold_wide > tmax_wide) ? TIMER_BITS'(tmax_wide) : TIMER_BITS'(hold_wide);

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    anc_fx_nxt  = anc_fx_r;
    anc_fy_nxt  = anc_fy_r;
    anc_sx_nxt  = anc_sx_r;
    anc_sy_nxt  = anc_sy_r;
    fresh_nxt   = fresh_r;
    running_nxt = running_r;
    remain_nxt  = remain_r;
    trig        = 1'b0;
    if (flags.operation == OP_TICK) begin
      if (running_r) begin
        if (remain_r > TIMER_BITS'(1)) begin
          remain_nxt = remain_r - TIMER_BITS'(1);
        end else begin
          remain_nxt  = '0;
          running_nxt = 1'b0;
          if (is_maybe) begin
            phase_nxt = PH_STARTED;
            fresh_nxt = 1'b1;
            trig      = 1'b1;
          end
        end
      end
    end else if (flags.ignore_request) begin
      if (is_active) begin
        phase_nxt = PH_FINISHED;
        trig      = 1'b1;
      end else if (is_maybe) begin
        running_nxt = 1'b0;
        phase_nxt   = PH_NONE;
        anc_fx_nxt  = '0;
        anc_fy_nxt  = '0;
        anc_sx_nxt  = '0;
        anc_sy_nxt  = '0;
      end
    end else if (!flags.points_present || !flags.inside_region) begin
      if (is_active) begin
        phase_nxt = PH_FINISHED;
        trig      = 1'b1;
      end else begin
        if (is_maybe) begin
          running_nxt = 1'b0;
        end
        phase_nxt  = PH_NONE;
        anc_fx_nxt = '0;
        anc_fy_nxt = '0;
        anc_sx_nxt = '0;
        anc_sy_nxt = '0;
      end
    end else if (fresh_r || (flags.action_code == ACT_UP)) begin
      case (flags.action_code)
        ACT_DOWN, ACT_PTR_DOWN: begin
          if (pair) begin
            anc_fx_nxt  = first_x;
            anc_fy_nxt  = first_y;
            anc_sx_nxt  = second_x;
            anc_sy_nxt  = second_y;
            phase_nxt   = PH_MAYBE;
            remain_nxt  = load;
            running_nxt = 1'b1;
          end else if (is_maybe) begin
            running_nxt = 1'b0;
            phase_nxt   = PH_NONE;
            anc_fx_nxt  = '0;
            anc_fy_nxt  = '0;
            anc_sx_nxt  = '0;
            anc_sy_nxt  = '0;
            fresh_nxt   = 1'b0;
          end else if (is_active) begin
            phase_nxt = PH_FINISHED;
            fresh_nxt = 1'b0;
            trig      = 1'b1;
          end
        end
        ACT_MOVE: begin
          if (pair && too_far) begin
            fresh_nxt = 1'b0;
            if (is_active) begin
              phase_nxt = PH_FINISHED;
              trig      = 1'b1;
            end else begin
              running_nxt = 1'b0;
              phase_nxt   = PH_NONE;
              anc_fx_nxt  = '0;
              anc_fy_nxt  = '0;
              anc_sx_nxt  = '0;
              anc_sy_nxt  = '0;
            end
          end
        end
        ACT_UP: begin
          if (is_maybe) begin
            running_nxt = 1'b0;
            phase_nxt   = PH_NONE;
            anc_fx_nxt  = '0;
            anc_fy_nxt  = '0;
            anc_sx_nxt  = '0;
            anc_sy_nxt  = '0;
          end else if (is_active) begin
            phase_nxt = PH_FINISHED;
            trig      = 1'b1;
          end
          fresh_nxt = 1'b1;
        end
        ACT_PTR_UP: begin
          if (pair) begin
            if (is_maybe) begin
              fresh_nxt   = 1'b0;
              running_nxt = 1'b0;
              phase_nxt   = PH_NONE;
              anc_fx_nxt  = '0;
              anc_fy_nxt  = '0;
              anc_sx_nxt  = '0;
              anc_sy_nxt  = '0;
            end else if (is_active) begin
              phase_nxt = PH_FINISHED;
              fresh_nxt = 1'b0;
              trig      = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result
  always_comb begin
    result.trigger       = trig;
    result.gesture_phase = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_NONE;
      anc_fx_r  <= '0;
      anc_fy_r  <= '0;
      anc_sx_r  <= '0;
      anc_sy_r  <= '0;
      fresh_r   <= 1'b1;
      running_r <= 1'b0;
      remain_r  <= '0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      anc_fx_r  <= anc_fx_nxt;
      anc_fy_r  <= anc_fy_nxt;
      anc_sx_r  <= anc_sx_nxt;
      anc_sy_r  <= anc_sy_nxt;
      fresh_r   <= fresh_nxt;
      running_r <= running_nxt;
      remain_r  <= remain_nxt;
    end
  end

  a_timer_only_when_maybe: assert property (@(posedge clk) disable iff (!rst_n)
    running_r == (phase_r == PH_MAYBE))
    else $error("hold timer state disagrees with maybe phase");

  a_start_from_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STARTED) && ($past(phase_r) != PH_STARTED) |-> $past(running_r))
    else $error("gesture started without a running hold timer");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(advance) |-> $stable(phase_r) && $stable(remain_r))
    else $error("gesture state changed without a transaction");

endmodule
`default_nettype wire

[hw/rtl/tfl_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfl_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module tfl_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire tfl_pkg::result_t result,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output tfl_pkg::result_t      out_result
);
  import tfl_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign room = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule
`default_nettype wire

[hw/rtl/two_finger_long_press_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_finger_long_press_detector
// Two-finger long press recognizer over touch events and timer ticks.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while in_stall is low and returns exactly
// one result per transaction, held first in the input register and then,
// through the gesture update, in the result register. The rate is set by the
// update of the gesture state, anchors and hold timer, which closes on itself.
// A waiting result still lets one more transaction into an empty input
// register; once that register is full, in_stall follows out_stall in the same
// cycle. Region membership arrives as a flag; the user must write configuration
// only while no transaction is in flight; the block does not enforce this.
module two_finger_long_press_detector #(
  parameter int COORD_BITS = 12,
  parameter int TIMER_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_write_en,
  input  wire logic [tfl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tfl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_operation,
  input  wire logic                            in_ignore_request,
  input  wire logic                            in_points_present,
  input  wire logic                            in_inside_region,
  input  wire logic [7:0]                      in_action_code,
  input  wire logic [3:0]                      in_point_count,
  input  wire logic [COORD_BITS-1:0]           in_first_x,
  input  wire logic [COORD_BITS-1:0]           in_first_y,
  input  wire logic [COORD_BITS-1:0]           in_second_x,
  input  wire logic [COORD_BITS-1:0]           in_second_y,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_trigger,
  output logic [2:0]                           out_gesture_phase
);
  import tfl_pkg::*;

  cfg_t                  cfg;
  flags_t                in_flags;
  flags_t                item_flags;
  logic                  item_valid;
  logic [COORD_BITS-1:0] item_first_x;
  logic [COORD_BITS-1:0] item_first_y;
  logic [COORD_BITS-1:0] item_second_x;
  logic [COORD_BITS-1:0] item_second_y;
  logic                  room;
  logic                  advance;
  result_t               result;
  result_t               out_result;

  assign in_flags.operation      = in_operation;
  assign in_flags.ignore_request = in_ignore_request;
  assign in_flags.points_present = in_points_present;
  assign in_flags.inside_region  = in_inside_region;
  assign in_flags.action_code    = in_action_code;
  assign in_flags.point_count    = in_point_count;

  assign advance = item_valid && room;

  tfl_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  tfl_in_stage #(
    .COORD_BITS (COORD_BITS)
  ) u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_flags      (in_flags),
    .in_first_x    (in_first_x),
    .in_first_y    (in_first_y),
    .in_second_x   (in_second_x),
    .in_second_y   (in_second_y),
    .advance       (advance),
    .item_valid    (item_valid),
    .item_flags    (item_flags),
    .item_first_x  (item_first_x),
    .item_first_y  (item_first_y),
    .item_second_x (item_second_x),
    .item_second_y (item_second_y)
  );

  tfl_core #(
    .COORD_BITS (COORD_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .cfg      (cfg),
    .flags    (item_flags),
    .first_x  (item_first_x),
    .first_y  (item_first_y),
    .second_x (item_second_x),
    .second_y (item_second_y),
    .result   (result)
  );

  tfl_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .result     (result),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_trigger       = out_result.trigger;
  assign out_gesture_phase = 3'(out_result.gesture_phase);

endmodule
`default_nettype wire
